// ===== rtl/salwc_pkg.sv =====
// Shared definitions for the set-associative LRU writeback cache unit.
// Holds default sizes, the lookup status struct and elaboration helpers.
// No dependencies.
package salwc_pkg;

    localparam int DEF_WAYS         = 4;
    localparam int DEF_BLOCK_BYTES  = 64;
    localparam int DEF_SETS         = 64;
    localparam int DEF_ADDRESS_BITS = 64;

    localparam int COUNT_W = 32;

    // Outcome of one lookup, passed from the lookup logic to the top level.
    typedef struct packed {
        logic hit;
        logic evicted;
        logic evicted_dirty;
    } salwc_status_t;

    // Largest n with 2**n <= v; used on constants only.
    function automatic int floor_log2(input int v);
        int r;
        r = 0;
        for (int i = 1; i < 31; i++) begin
            if ((v >> i) != 0) begin
                r = i;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/salwc_row_ram.sv =====
// Set row memory: one word per set holding tags, dirty bits and LRU ranks.
// One write port, one registered read port, write-first on a collision.
// Depends on nothing.
module salwc_row_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 224
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Forward the row being written so a back-to-back access to the same set
    // sees the latest state.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/salwc_lookup.sv =====
// Way compare, victim selection and row update for one access.
// Depends on salwc_pkg (status struct).
module salwc_lookup #(
    parameter int WAYS   = 4,
    parameter int TAG_W  = 52,
    parameter int RANK_W = 2
) (
    input  logic [WAYS*(TAG_W+1+RANK_W)-1:0] row_rd,
    input  logic [WAYS-1:0]                  set_valid,
    input  logic [TAG_W-1:0]                 tag,
    input  logic                             write,
    output logic [WAYS*(TAG_W+1+RANK_W)-1:0] row_wr,
    output logic [WAYS-1:0]                  valid_wr,
    output salwc_pkg::salwc_status_t         status,
    output logic [TAG_W-1:0]                 ev_tag
);

    localparam int DIRTY_LO = WAYS * TAG_W;
    localparam int RANK_LO  = WAYS * (TAG_W + 1);

    logic [TAG_W-1:0]  tag_v   [WAYS];
    logic [WAYS-1:0]   dirty_v;
    logic [RANK_W-1:0] rank_v  [WAYS];
    logic              hit_found;
    logic              inv_found;
    logic [RANK_W-1:0] hit_way;
    logic [RANK_W-1:0] inv_way;
    logic [RANK_W-1:0] lru_way;
    logic [RANK_W-1:0] way;
    logic [RANK_W-1:0] old_rank;

    // Unpack the row; a set with no valid line still has its reset ranks.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            tag_v[w]   = row_rd[w*TAG_W +: TAG_W];
            dirty_v[w] = row_rd[DIRTY_LO + w];
            if (set_valid == '0) begin
                rank_v[w] = RANK_W'(w);
            end else begin
                rank_v[w] = row_rd[RANK_LO + w*RANK_W +: RANK_W];
            end
        end
    end

    // Ranks form a permutation, so the LRU way is the one at rank zero.
    always_comb begin
        hit_found = 1'b0;
        inv_found = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        lru_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (set_valid[w] && (tag_v[w] == tag)) begin
                hit_found = 1'b1;
                hit_way   = RANK_W'(w);
            end
            if (!set_valid[w]) begin
                inv_found = 1'b1;
                inv_way   = RANK_W'(w);
            end
            if (rank_v[w] == '0) begin
                lru_way = RANK_W'(w);
            end
        end
        if (hit_found) begin
            way = hit_way;
        end else if (inv_found) begin
            way = inv_way;
        end else begin
            way = lru_way;
        end
        old_rank = rank_v[way];
    end

    always_comb begin
        status.hit           = hit_found;
        status.evicted       = !hit_found && !inv_found;
        status.evicted_dirty = !hit_found && !inv_found && dirty_v[way];
        ev_tag               = tag_v[way];
    end

    // Build the updated row: fill or mark dirty, then move the way to MRU.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            if (RANK_W'(w) == way) begin
                row_wr[w*TAG_W +: TAG_W]                = hit_found ? tag_v[w] : tag;
                row_wr[DIRTY_LO + w]                    = hit_found ? (dirty_v[w] | write)
                                                                    : write;
                row_wr[RANK_LO + w*RANK_W +: RANK_W]    = RANK_W'(WAYS - 1);
                valid_wr[w]                             = 1'b1;
            end else begin
                row_wr[w*TAG_W +: TAG_W]                = tag_v[w];
                row_wr[DIRTY_LO + w]                    = dirty_v[w];
                row_wr[RANK_LO + w*RANK_W +: RANK_W]    = (rank_v[w] > old_rank)
                                                          ? rank_v[w] - 1'b1 : rank_v[w];
                valid_wr[w]                             = set_valid[w];
            end
        end
    end

endmodule

// ===== rtl/set_assoc_lru_writeback_cache_unit.sv =====
// Top level of the set-associative LRU writeback cache bookkeeping unit.
// Depends on salwc_pkg, salwc_row_ram and salwc_lookup.
//
//   Channel  Ports                                   Direction  Carries
//   s_       s_valid s_ready s_address s_command     in         one access item
//   m_       m_valid m_ready m_hit m_evicted ...     out        one result item
//
// Throughput: one item per cycle sustained while m_ready keeps the result register
// drained. The row is read as an item is accepted into the input stage; its lookup
// then lands in the result register.
// The row memory's single read port and the write-first forward set this pace.
// Reset: aresetn low clears valid bits, counters and both pipeline stages at
// once; no clearing pass. Ranks of a set with no valid line read as way index.
// Stalls: the lookup stage holds while the result register is full and not
// taken; the input stays ready whenever the lookup stage can advance.
module set_assoc_lru_writeback_cache_unit #(
    parameter int WAYS         = salwc_pkg::DEF_WAYS,
    parameter int BLOCK_BYTES  = salwc_pkg::DEF_BLOCK_BYTES,
    parameter int SETS         = salwc_pkg::DEF_SETS,
    parameter int ADDRESS_BITS = salwc_pkg::DEF_ADDRESS_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_address,
    input  logic        s_command,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic        m_evicted,
    output logic        m_evicted_dirty,
    output logic [63:0] m_evicted_address,
    output logic [31:0] m_hit_total,
    output logic [31:0] m_miss_total,
    output logic [31:0] m_dirty_eviction_total,
    output logic [31:0] m_clean_eviction_total
);

    // Address split: | tag | set index | block offset |
    localparam int OFFSET_BITS = salwc_pkg::floor_log2(BLOCK_BYTES);
    localparam int INDEX_BITS  = salwc_pkg::floor_log2(SETS);
    localparam int NUM_ROWS    = 1 << INDEX_BITS;
    localparam int SET_W       = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int TAG_SHIFT   = OFFSET_BITS + INDEX_BITS;
    localparam int TAG_RAW     = ADDRESS_BITS - TAG_SHIFT;
    localparam int TAG_W       = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int RANK_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W       = WAYS * (TAG_W + 1 + RANK_W);
    localparam int CW          = salwc_pkg::COUNT_W;

    localparam logic [63:0] SET_MASK  = (64'd1 << INDEX_BITS) - 64'd1;
    localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDRESS_BITS);

    // ---------------------------------------------------------------
    // Input stage: accepted item waits here while its row is read
    // ---------------------------------------------------------------
    logic                    s1_valid_reg;
    logic [ADDRESS_BITS-1:0] s1_addr_reg;
    logic                    s1_write_reg;

    logic                    advance;
    logic                    accept;
    logic [SET_W-1:0]        in_set;
    logic [SET_W-1:0]        s1_set;
    logic [TAG_W-1:0]        s1_tag;

    // Advance the lookup stage when the result register is free or drained.
    assign advance = s1_valid_reg && (!m_valid || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign in_set = SET_W'((s_address[ADDRESS_BITS-1:0] >> OFFSET_BITS) & SET_MASK);
    assign s1_set = SET_W'((s1_addr_reg >> OFFSET_BITS) & SET_MASK);
    assign s1_tag = TAG_W'(s1_addr_reg >> TAG_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; load only on accept.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg  <= s_address[ADDRESS_BITS-1:0];
            s1_write_reg <= s_command;
        end
    end

    // ---------------------------------------------------------------
    // Line state: valid bits in flops, everything else in the row memory
    // ---------------------------------------------------------------
    logic [WAYS-1:0]  valid_reg [NUM_ROWS];
    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] row_wr;
    logic [WAYS-1:0]  valid_wr;

    salwc_row_ram #(
        .DEPTH  (NUM_ROWS),
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_row_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (in_set),
        .rd_data (row_rd),
        .wr_en   (advance),
        .wr_addr (s1_set),
        .wr_data (row_wr)
    );

    // Valid bits never drop once set; they are written with the row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                valid_reg[r] <= '0;
            end
        end else if (advance) begin
            valid_reg[s1_set] <= valid_wr;
        end
    end

    // ---------------------------------------------------------------
    // Lookup: compare ways, pick victim, update recency
    // ---------------------------------------------------------------
    salwc_pkg::salwc_status_t status;
    logic [TAG_W-1:0]         ev_tag;
    logic [63:0]              ev_addr;

    salwc_lookup #(
        .WAYS   (WAYS),
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W)
    ) u_lookup (
        .row_rd    (row_rd),
        .set_valid (valid_reg[s1_set]),
        .tag       (s1_tag),
        .write     (s1_write_reg),
        .row_wr    (row_wr),
        .valid_wr  (valid_wr),
        .status    (status),
        .ev_tag    (ev_tag)
    );

    // Rebuild the victim's block address, offset bits zero.
    assign ev_addr = ((64'(ev_tag) << TAG_SHIFT) | (64'(s1_set) << OFFSET_BITS)) & ADDR_MASK;

    // ---------------------------------------------------------------
    // Result register and saturating counters
    // ---------------------------------------------------------------
    logic          m_valid_reg;
    logic          m_hit_reg;
    logic          m_evicted_reg;
    logic          m_evicted_dirty_reg;
    logic [63:0]   m_evicted_address_reg;
    logic [CW-1:0] hit_total_reg;
    logic [CW-1:0] miss_total_reg;
    logic [CW-1:0] dirty_total_reg;
    logic [CW-1:0] clean_total_reg;
    logic [CW-1:0] hit_total_next;
    logic [CW-1:0] miss_total_next;
    logic [CW-1:0] dirty_total_next;
    logic [CW-1:0] clean_total_next;

    // Counters stop at all ones.
    always_comb begin
        hit_total_next   = hit_total_reg;
        miss_total_next  = miss_total_reg;
        dirty_total_next = dirty_total_reg;
        clean_total_next = clean_total_reg;
        if (status.hit) begin
            if (hit_total_reg != '1) begin
                hit_total_next = hit_total_reg + 1'b1;
            end
        end else if (miss_total_reg != '1) begin
            miss_total_next = miss_total_reg + 1'b1;
        end
        if (status.evicted) begin
            if (status.evicted_dirty) begin
                if (dirty_total_reg != '1) begin
                    dirty_total_next = dirty_total_reg + 1'b1;
                end
            end else if (clean_total_reg != '1) begin
                clean_total_next = clean_total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            dirty_total_reg <= '0;
            clean_total_reg <= '0;
        end else if (advance) begin
            m_valid_reg     <= 1'b1;
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            dirty_total_reg <= dirty_total_next;
            clean_total_reg <= clean_total_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Drop eviction fields to zero unless a valid line was displaced.
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_hit_reg             <= status.hit;
            m_evicted_reg         <= status.evicted;
            m_evicted_dirty_reg   <= status.evicted_dirty;
            m_evicted_address_reg <= status.evicted ? ev_addr : 64'd0;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_hit                  = m_hit_reg;
    assign m_evicted              = m_evicted_reg;
    assign m_evicted_dirty        = m_evicted_dirty_reg;
    assign m_evicted_address      = m_evicted_address_reg;
    assign m_hit_total            = hit_total_reg;
    assign m_miss_total           = miss_total_reg;
    assign m_dirty_eviction_total = dirty_total_reg;
    assign m_clean_eviction_total = clean_total_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted))
        else $error("hit result also reports an eviction");

    a_dirty_needs_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted_dirty) |-> m_evicted)
        else $error("dirty eviction flagged without eviction");

    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && status.hit && (hit_total_reg != '1))
        |=> (m_hit_total == $past(hit_total_reg) + 1'b1))
        else $error("hit count did not advance on a hit");

    a_miss_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !status.hit)
        |=> ((m_miss_total != $past(miss_total_reg)) || (m_miss_total == '1)))
        else $error("miss count did not advance on a miss");

endmodule

// ===== dv/set_assoc_lru_writeback_cache_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_lru_writeback_cache_unit: it mirrors the tag, valid,
// dirty and LRU bookkeeping and checks every result item against its own prediction.
// Depends on salwc_pkg (default sizes) and the cache unit RTL.
module set_assoc_lru_writeback_cache_unit_tb;

    // Sizes follow the defaults that the unit is built with.
    localparam int WAYS         = salwc_pkg::DEF_WAYS;
    localparam int BLOCK_BYTES  = salwc_pkg::DEF_BLOCK_BYTES;
    localparam int SETS         = salwc_pkg::DEF_SETS;
    localparam int ADDRESS_BITS = salwc_pkg::DEF_ADDRESS_BITS;
    localparam int COUNT_W      = salwc_pkg::COUNT_W;

    localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
    localparam int SET_BITS  = $clog2(SETS);
    localparam int LINES     = WAYS * SETS;
    localparam int RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [63:0] ADDR_MASK =
        (ADDRESS_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam logic [63:0] SET_MASK = (64'd1 << SET_BITS) - 64'd1;

    // Access commands carried by s_command.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam int RANDOM_PER_PHASE = 545;
    localparam int QUIET_LIMIT      = 2000;
    localparam int TAG_POOL         = 7;
    localparam int SET_POOL         = 3;

    typedef struct {
        logic               hit;
        logic               evicted;
        logic               evicted_dirty;
        logic [63:0]        evicted_address;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] dirty_eviction_total;
        logic [COUNT_W-1:0] clean_eviction_total;
    } access_outcome_t;

    // Mirror of the cache bookkeeping plus the queue of outcomes still owed by the unit.
    class lru_cache_mirror;
        logic [63:0]        line_tag   [LINES];
        bit                 line_valid [LINES];
        bit                 line_dirty [LINES];
        bit [RANK_W-1:0]    line_rank  [LINES];
        bit [COUNT_W-1:0]   hits_tallied;
        bit [COUNT_W-1:0]   misses_tallied;
        bit [COUNT_W-1:0]   dirty_evict_count;
        bit [COUNT_W-1:0]   clean_evict_count;
        access_outcome_t    pending_outcomes[$];
        int                 failures;
        int                 accesses;

        function new();
            for (int i = 0; i < LINES; i++) begin
                line_tag[i]   = '0;
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_rank[i]  = RANK_W'(i % WAYS);
            end
            hits_tallied      = '0;
            misses_tallied    = '0;
            dirty_evict_count = '0;
            clean_evict_count = '0;
            failures          = 0;
            accesses          = 0;
        endfunction

        function bit [COUNT_W-1:0] bump(bit [COUNT_W-1:0] count);
            return (count == '1) ? count : count + 1'b1;
        endfunction

        // Make one way the most recent of its set; ranks above it slide down by one.
        function void promote(int base, int way);
            bit [RANK_W-1:0] old_rank;
            old_rank = line_rank[base + way];
            for (int w = 0; w < WAYS; w++) begin
                if (line_rank[base + w] > old_rank) begin
                    line_rank[base + w]--;
                end
            end
            line_rank[base + way] = RANK_W'(WAYS - 1);
        endfunction

        function void record_access(logic [63:0] address, logic command);
            logic [63:0]     addr;
            logic [63:0]     tag;
            int              set_idx;
            int              base;
            int              way;
            access_outcome_t outcome;
            addr    = address & ADDR_MASK;
            set_idx = int'((addr >> OFF_BITS) & SET_MASK);
            tag     = addr >> (OFF_BITS + SET_BITS);
            base    = set_idx * WAYS;
            way     = WAYS;
            outcome = '{default: '0};
            accesses++;

            for (int w = 0; w < WAYS; w++) begin
                if (way == WAYS && line_valid[base + w] && line_tag[base + w] == tag) begin
                    way = w;
                end
            end

            if (way < WAYS) begin
                outcome.hit = 1'b1;
                if (command == CMD_WRITE) begin
                    line_dirty[base + way] = 1'b1;
                end
                hits_tallied = bump(hits_tallied);
                promote(base, way);
            end else begin
                misses_tallied = bump(misses_tallied);
                for (int w = 0; w < WAYS; w++) begin
                    if (way == WAYS && !line_valid[base + w]) begin
                        way = w;
                    end
                end
                // No free way: displace the least recent line of the set.
                if (way == WAYS) begin
                    way = 0;
                    for (int w = 1; w < WAYS; w++) begin
                        if (line_rank[base + w] < line_rank[base + way]) begin
                            way = w;
                        end
                    end
                    outcome.evicted         = 1'b1;
                    outcome.evicted_dirty   = line_dirty[base + way];
                    outcome.evicted_address = ((line_tag[base + way] << (OFF_BITS + SET_BITS))
                        | (64'(set_idx) << OFF_BITS)) & ADDR_MASK;
                    if (line_dirty[base + way]) begin
                        dirty_evict_count = bump(dirty_evict_count);
                    end else begin
                        clean_evict_count = bump(clean_evict_count);
                    end
                end
                line_tag[base + way]   = tag;
                line_valid[base + way] = 1'b1;
                line_dirty[base + way] = (command == CMD_WRITE);
                promote(base, way);
            end

            outcome.hit_total            = hits_tallied;
            outcome.miss_total           = misses_tallied;
            outcome.dirty_eviction_total = dirty_evict_count;
            outcome.clean_eviction_total = clean_evict_count;
            pending_outcomes.push_back(outcome);
        endfunction

        function void match_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            end
        endfunction

        function void compare_outcome(access_outcome_t got);
            access_outcome_t want;
            if (pending_outcomes.size() == 0) begin
                failures++;
                $display("%0t: result item with no access outstanding, expected none, actual hit=%0b",
                         $time, got.hit);
                return;
            end
            want = pending_outcomes.pop_front();
            match_field("hit", want.hit, got.hit);
            match_field("evicted", want.evicted, got.evicted);
            match_field("evicted_dirty", want.evicted_dirty, got.evicted_dirty);
            match_field("evicted_address", want.evicted_address, got.evicted_address);
            match_field("hit_total", want.hit_total, got.hit_total);
            match_field("miss_total", want.miss_total, got.miss_total);
            match_field("dirty_eviction_total", want.dirty_eviction_total,
                        got.dirty_eviction_total);
            match_field("clean_eviction_total", want.clean_eviction_total,
                        got.clean_eviction_total);
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [63:0] s_address = '0;
    logic        s_command = CMD_READ;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_hit;
    logic        m_evicted;
    logic        m_evicted_dirty;
    logic [63:0] m_evicted_address;
    logic [31:0] m_hit_total;
    logic [31:0] m_miss_total;
    logic [31:0] m_dirty_eviction_total;
    logic [31:0] m_clean_eviction_total;

    lru_cache_mirror mirror = new();

    // Idle and stall rates in percent of cycles; each phase of the run sets them.
    int send_idle_pct  = 0;
    int take_stall_pct = 0;

    logic [63:0] tag_pool [TAG_POOL];
    logic [63:0] set_pool [SET_POOL];

    set_assoc_lru_writeback_cache_unit uut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_address              (s_address),
        .s_command              (s_command),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_hit                  (m_hit),
        .m_evicted              (m_evicted),
        .m_evicted_dirty        (m_evicted_dirty),
        .m_evicted_address      (m_evicted_address),
        .m_hit_total            (m_hit_total),
        .m_miss_total           (m_miss_total),
        .m_dirty_eviction_total (m_dirty_eviction_total),
        .m_clean_eviction_total (m_clean_eviction_total)
    );

    always #5 aclk = ~aclk;

    // Result side: check the item taken at this edge, then pick ready for the next cycle.
    // Both reads see pre-edge values, so the check never races the unit's own updates.
    always @(posedge aclk) begin
        access_outcome_t got;
        if (aresetn && m_valid && m_ready) begin
            got.hit                  = m_hit;
            got.evicted              = m_evicted;
            got.evicted_dirty        = m_evicted_dirty;
            got.evicted_address      = m_evicted_address;
            got.hit_total            = m_hit_total;
            got.miss_total           = m_miss_total;
            got.dirty_eviction_total = m_dirty_eviction_total;
            got.clean_eviction_total = m_clean_eviction_total;
            mirror.compare_outcome(got);
        end
        m_ready <= ($urandom_range(99) >= take_stall_pct);
    end

    // Offer one access item and hold it until the unit takes it. Idle cycles go first,
    // with valid low; valid is never dropped between back-to-back items.
    task automatic push_access(input logic [63:0] addr, input logic command);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_address <= addr;
        s_command <= command;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        mirror.record_access(addr, command);
    endtask

    // Edge cases: cold fills, hits at both ends of a block, a write hit that dirties a
    // clean line, clean and dirty evictions in set 0, the all-ones address in the top set
    // and its later dirty eviction, and alternating bit patterns.
    task automatic run_directed();
        push_access(64'h0000_0000_0000_0000, CMD_READ);
        push_access(64'h0000_0000_0000_003F, CMD_READ);
        push_access(64'h0000_0000_0000_1000, CMD_WRITE);
        push_access(64'h0000_0000_0000_2000, CMD_READ);
        push_access(64'h0000_0000_0000_3000, CMD_READ);
        push_access(64'h0000_0000_0000_0000, CMD_WRITE);
        push_access(64'h0000_0000_0000_4000, CMD_READ);
        push_access(64'h0000_0000_0000_5000, CMD_READ);
        push_access(64'h0000_0000_0000_1000, CMD_WRITE);
        push_access(64'h0000_0000_0000_4000, CMD_READ);
        push_access(64'hFFFF_FFFF_FFFF_FFFF, CMD_WRITE);
        push_access(64'hFFFF_FFFF_FFFF_FFC0, CMD_READ);
        push_access(64'h8000_0000_0000_0000, CMD_READ);
        push_access(64'hAAAA_AAAA_AAAA_AAAA, CMD_WRITE);
        push_access(64'h5555_5555_5555_5555, CMD_READ);
        push_access(64'h0000_0000_0000_6000, CMD_WRITE);
        for (int k = 1; k <= WAYS; k++) begin
            push_access(64'h0000_0000_0000_0FC0 | (64'(k) << (OFF_BITS + SET_BITS)), CMD_READ);
        end
    endtask

    // Random accesses, mostly drawn from a few sets and a small tag pool so that sets
    // overflow and lines cycle through hit, clean and dirty eviction; the rest are
    // new tags in the hot sets and fully random addresses.
    task automatic run_random_phase(input int count);
        logic [63:0] addr;
        int          pick;
        for (int i = 0; i < SET_POOL; i++) begin
            set_pool[i] = 64'($urandom_range(SETS - 1));
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                addr = {$urandom, $urandom};
            end else begin
                if (pick < 20) begin
                    addr = {$urandom, $urandom} << (OFF_BITS + SET_BITS);
                end else begin
                    addr = tag_pool[$urandom_range(TAG_POOL - 1)] << (OFF_BITS + SET_BITS);
                end
                addr |= set_pool[$urandom_range(SET_POOL - 1)] << OFF_BITS;
                addr |= 64'($urandom_range(BLOCK_BYTES - 1));
            end
            push_access(addr, $urandom_range(1) ? CMD_WRITE : CMD_READ);
        end
    endtask

    // Watchdog: end the run when neither channel moves an item for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        // Keep the extremes of the tag range in the pool, fill the rest at random.
        tag_pool[0] = '0;
        tag_pool[1] = ADDR_MASK >> (OFF_BITS + SET_BITS);
        for (int i = 2; i < TAG_POOL; i++) begin
            tag_pool[i] = {$urandom, $urandom} >> (OFF_BITS + SET_BITS);
        end

        // Hold reset at the start, then release it for good.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles lightly while the receiver stalls heavily.
        send_idle_pct  = 14;
        take_stall_pct = 77;
        run_directed();
        run_random_phase(RANDOM_PER_PHASE);

        // Swap the pressure: sparse input, eager receiver.
        send_idle_pct  = 77;
        take_stall_pct = 14;
        run_random_phase(RANDOM_PER_PHASE);

        // Full rate on both sides.
        send_idle_pct  = 0;
        take_stall_pct = 0;
        run_random_phase(RANDOM_PER_PHASE);
        s_valid <= 1'b0;

        // Drain the owed results, then wait for any stray item.
        while (mirror.pending_outcomes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        $display("Ran %0d accesses over three idle/stall mixes: %0d hits, %0d misses,",
                 mirror.accesses, mirror.hits_tallied, mirror.misses_tallied);
        $display("  %0d dirty and %0d clean evictions, %0d field mismatches",
                 mirror.dirty_evict_count, mirror.clean_evict_count, mirror.failures);
        if (mirror.failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
